[rtl/core/process_fifo_with_keyed_removal_defines.svh]
// Assertion helpers for the checker of the process queue.
`ifndef PROCESS_FIFO_WITH_KEYED_REMOVAL_DEFINES_SVH
`define PROCESS_FIFO_WITH_KEYED_REMOVAL_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PFKR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PFKR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/pfkr_pkg.sv]
package pfkr_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int FUNC_W          = 2;
  localparam int PID_W           = 8;
  localparam int COUNT_OUT_W     = 5;

  // Operation codes carried by func.
  localparam logic [FUNC_W-1:0] FUNC_ENQ    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  // One result as it travels from the sequencer to the output register.
  typedef struct packed {
    logic                   found;
    logic [PID_W-1:0]       out_pid;
    logic                   full_reject;
    logic [COUNT_OUT_W-1:0] count_after;
  } result_t;

endpackage

[rtl/core/pfkr_ram.sv]
module pfkr_ram #(
  parameter int DEPTH = pfkr_pkg::QUEUE_DEPTH_DEF,
  parameter int WIDTH = pfkr_pkg::PID_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/pfkr_ctrl.sv]
module pfkr_ctrl #(
  parameter int QUEUE_DEPTH = pfkr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pfkr_pkg::FUNC_W-1:0]    func,
  input  logic [pfkr_pkg::PID_W-1:0]     pid,
  input  logic                           res_free,
  output logic                           res_load,
  output pfkr_pkg::result_t              res,
  output logic                           ram_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0] ram_waddr,
  output logic [pfkr_pkg::PID_W-1:0]     ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(QUEUE_DEPTH)-1:0] ram_raddr,
  input  logic [pfkr_pkg::PID_W-1:0]     ram_rdata
);
  import pfkr_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR   = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   WRAP_SUM   = (CW+1)'(QUEUE_DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DEQ   = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_SHIFT = 2'd3;

  logic [1:0]       state, state_next;
  logic [AW-1:0]    head, head_next;
  logic [CW-1:0]    count, count_next;
  logic [AW-1:0]    rd_ptr, rd_ptr_next;
  logic [AW-1:0]    wr_ptr, wr_ptr_next;
  logic [CW-1:0]    idx, idx_next;
  logic [PID_W-1:0] key, key_next;
  logic [PID_W-1:0] got, got_next;

  logic [CW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic [CW-1:0] count_last;
  logic          accept;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [COUNT_OUT_W-1:0] out_count(input logic [CW-1:0] c);
    logic [CW+COUNT_OUT_W-1:0] w;
    w = {{COUNT_OUT_W{1'b0}}, c};
    return w[COUNT_OUT_W-1:0];
  endfunction

  // The tail slot wraps around the circular store.
  assign tail_sum   = (CW+1)'(head) + (CW+1)'(count);
  assign tail       = (tail_sum >= WRAP_SUM) ? AW'(tail_sum - WRAP_SUM) : AW'(tail_sum);
  assign count_last = count - 1'b1;

  assign in_ready = (state == S_IDLE) && res_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next  = state;
    head_next   = head;
    count_next  = count;
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    idx_next    = idx;
    key_next    = key;
    got_next    = got;
    ram_we      = 1'b0;
    ram_waddr   = wr_ptr;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = head;
    res_load    = 1'b0;
    res         = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (func)
            FUNC_ENQ: begin
              res_load = 1'b1;
              if (count == FULL_COUNT) begin
                res.full_reject = 1'b1;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = tail;
                ram_wdata  = pid;
                count_next = count + 1'b1;
              end
            end
            FUNC_DEQ: begin
              if (count == '0) begin
                res_load = 1'b1;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = head;
                state_next = S_DEQ;
              end
            end
            FUNC_REMOVE: begin
              key_next = pid;
              if (count == '0) begin
                res_load = 1'b1;
              end else begin
                ram_re      = 1'b1;
                ram_raddr   = head;
                rd_ptr_next = head;
                idx_next    = '0;
                state_next  = S_SCAN;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end

      S_DEQ: begin
        res_load    = 1'b1;
        res.found   = 1'b1;
        res.out_pid = ram_rdata;
        head_next   = ptr_inc(head);
        count_next  = count_last;
        state_next  = S_IDLE;
      end

      S_SCAN: begin
        if (ram_rdata == key) begin
          if (idx == '0) begin
            // Match at the head: just advance the head.
            head_next   = ptr_inc(head);
            count_next  = count_last;
            res_load    = 1'b1;
            res.found   = 1'b1;
            res.out_pid = ram_rdata;
            state_next  = S_IDLE;
          end else if (idx == count_last) begin
            // Match at the tail: just drop it.
            count_next  = count_last;
            res_load    = 1'b1;
            res.found   = 1'b1;
            res.out_pid = ram_rdata;
            state_next  = S_IDLE;
          end else begin
            // Match in the middle: close the gap by moving later entries up.
            got_next    = ram_rdata;
            wr_ptr_next = rd_ptr;
            rd_ptr_next = ptr_inc(rd_ptr);
            ram_re      = 1'b1;
            ram_raddr   = ptr_inc(rd_ptr);
            idx_next    = idx + 1'b1;
            state_next  = S_SHIFT;
          end
        end else if (idx == count_last) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end else begin
          rd_ptr_next = ptr_inc(rd_ptr);
          ram_re      = 1'b1;
          ram_raddr   = ptr_inc(rd_ptr);
          idx_next    = idx + 1'b1;
        end
      end

      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = wr_ptr;
        ram_wdata = ram_rdata;
        if (idx == count_last) begin
          count_next  = count_last;
          res_load    = 1'b1;
          res.found   = 1'b1;
          res.out_pid = got;
          state_next  = S_IDLE;
        end else begin
          wr_ptr_next = rd_ptr;
          rd_ptr_next = ptr_inc(rd_ptr);
          ram_re      = 1'b1;
          ram_raddr   = ptr_inc(rd_ptr);
          idx_next    = idx + 1'b1;
        end
      end
    endcase

    res.count_after = out_count(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr <= rd_ptr_next;
    wr_ptr <= wr_ptr_next;
    idx    <= idx_next;
    key    <= key_next;
    got    <= got_next;
  end

endmodule

[rtl/core/process_fifo_with_keyed_removal.sv]
// Enqueue, unused codes and requests on an empty queue pass their result to the output register
// in the cycle they are taken; dequeue first reads the head identifier, and remove-by-id scans
// the entries held from the head, reading the identifier memory once per cycle as it scans
// for the match and closes any gap. Input waits until the last transaction's result is loaded.
// Reset (rst, synchronous, active high) empties the queue and drops any pending result;
// the identifier memory itself is not cleared and needs no clearing pass.
module process_fifo_with_keyed_removal #(
  parameter int QUEUE_DEPTH = pfkr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pfkr_pkg::FUNC_W-1:0]      func,
  input  logic [pfkr_pkg::PID_W-1:0]       pid,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             found,
  output logic [pfkr_pkg::PID_W-1:0]       out_pid,
  output logic                             full_reject,
  output logic [pfkr_pkg::COUNT_OUT_W-1:0] count_after
);
  import pfkr_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  // The queue lives in a circular store of identifiers. The sequencer keeps the head
  // pointer and the entry count in flip-flops and reaches the identifiers only through
  // a memory with one write port and one registered read port.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [PID_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [PID_W-1:0] ram_rdata;

  // A finished result is handed over as one struct and held in the output register
  // until the downstream side takes the transaction.
  logic    res_free;
  logic    res_load;
  result_t res;
  result_t res_q;

  pfkr_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (PID_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfkr_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .pid       (pid),
    .res_free  (res_free),
    .res_load  (res_load),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // The output slot counts as free when it is empty or is being emptied in this cycle,
  // so a new transaction can be taken in the same cycle that the old result leaves.
  assign res_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign found       = res_q.found;
  assign out_pid     = res_q.out_pid;
  assign full_reject = res_q.full_reject;
  assign count_after = res_q.count_after;

endmodule

[rtl/core/pfkr_checker.sv]
`include "process_fifo_with_keyed_removal_defines.svh"

module pfkr_checker #(
  parameter int QUEUE_DEPTH = pfkr_pkg::QUEUE_DEPTH_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             found,
  input logic [pfkr_pkg::PID_W-1:0]       out_pid,
  input logic                             full_reject,
  input logic [pfkr_pkg::COUNT_OUT_W-1:0] count_after
);
  import pfkr_pkg::*;

  localparam bit COUNT_WRAPS = (QUEUE_DEPTH > 31);
  localparam logic [COUNT_OUT_W-1:0] DEPTH_OUT = COUNT_OUT_W'(QUEUE_DEPTH);

  `PFKR_ASSERT_NOW(a_pid_zero_when_absent, clk, rst, out_valid && !found, out_pid == '0, "out_pid must be zero when nothing was removed")
  `PFKR_ASSERT_NOW(a_reject_excludes_found, clk, rst, out_valid && full_reject, !found, "a refused enqueue cannot return an identifier")
  `PFKR_ASSERT_NOW(a_count_in_range, clk, rst, out_valid, COUNT_WRAPS || (count_after <= DEPTH_OUT), "count_after exceeds the queue depth")
  `PFKR_ASSERT_NOW(a_stalled_result_blocks_input, clk, rst, in_valid && out_valid && !out_ready, !in_ready, "input taken while a result waits")
  `PFKR_ASSERT_NEXT(a_result_held, clk, rst, out_valid && !out_ready, out_valid && $stable(found) && $stable(out_pid) && $stable(full_reject) && $stable(count_after), "a stalled result changed")

endmodule

bind process_fifo_with_keyed_removal pfkr_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_pfkr_checker (.*);
